/* hw/rtl/window_stability_classifier_core_defines.svh */
// Assertion macros shared by the checker of the window stability classifier.
// No dependencies; take in with `include before use.
`ifndef WINDOW_STABILITY_CLASSIFIER_CORE_DEFINES_SVH
`define WINDOW_STABILITY_CLASSIFIER_CORE_DEFINES_SVH

// Implication checked in the same cycle, off while reset is high.
`define WSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, off while reset is high.
`define WSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication checked in the next cycle, live through reset.
`define WSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/wsc_pkg.sv */
// Types and constants for the window stability classifier.
// No dependencies; used by every module of the block.
package wsc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_SPREAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] STABLE_SPREAD_RST = 16'd5;
  localparam logic [CFG_W-1:0] LOW_THRESHOLD_RST = 16'd370;
  localparam logic [CFG_W-1:0] HIGH_THRESHOLD_RST = 16'd380;

  // Command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Level codes.
  localparam logic [1:0] LEVEL_LOW  = 2'd0;
  localparam logic [1:0] LEVEL_BAND = 2'd1;
  localparam logic [1:0] LEVEL_HIGH = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic                stable;
    logic [SAMPLE_W-1:0] spread;
    logic [SAMPLE_W-1:0] mean_value;
    logic [1:0]          level;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/wsc_cell.sv */
// One window entry of the sample ring.
// Depends on wsc_pkg for the control struct and sample width.
module wsc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  wsc_pkg::cell_ctrl_t          ctrl,
  input  logic [wsc_pkg::SAMPLE_W-1:0] din,
  output logic [wsc_pkg::SAMPLE_W-1:0] dout
);

  logic [wsc_pkg::SAMPLE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      value <= '0;
    end else if (ctrl.shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

/* hw/rtl/wsc_divider.sv */
// Division by a fixed divisor through a multiply by its rounded-up reciprocal, dividend and quotient registered.
// Depends on wsc_pkg for the sample width; the dividend's top part must be below DIVISOR.
module wsc_divider #(
  parameter int DIVISOR = 8,
  parameter int HI_W    = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [HI_W-1:0]              dividend_hi,
  input  logic [wsc_pkg::SAMPLE_W-1:0] dividend_lo,
  output logic                         done,
  output logic [wsc_pkg::SAMPLE_W-1:0] quotient
);

  localparam int DIV_W   = wsc_pkg::SAMPLE_W + HI_W;
  localparam int SHIFT   = DIV_W + HI_W;
  localparam int RECIP_W = DIV_W + 1;
  localparam int PROD_W  = DIV_W + RECIP_W;
  // ceil(2^SHIFT / DIVISOR); exact floor for every dividend below 2^DIV_W
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  logic                         pend;
  logic [DIV_W-1:0]             dividend;
  logic [PROD_W-1:0]            product;
  logic [wsc_pkg::SAMPLE_W-1:0] quo;

  assign product = PROD_W'(dividend) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {dividend_hi, dividend_lo};
    end
    if (pend) begin
      quo <= product[SHIFT +: wsc_pkg::SAMPLE_W];
    end
  end

  assign quotient = quo;

endmodule

/* hw/rtl/window_stability_classifier_core.sv */
// Window stability classifier. Samples sit in a ring of WINDOW_DEPTH cells; a sample
// beat shifts the new value in at the head and drops the oldest entry, a clear beat
// zeroes every cell. After each sample the ring rotates once round, one cell a cycle,
// while the maximum, minimum and sum are gathered from the tail cell; the floored mean
// then comes from a multiply by the reciprocal of the depth in the divider. A sample
// beat yields its result after the ring walk and the divide; a clear beat goes
// straight to the finish state and yields its all-zero result. Results wait in an
// output register; one item is in work at a time, and a result still waiting holds
// the next one back in its finish state.
module window_stability_classifier_core #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  wsc_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output wsc_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [wsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsc_pkg::CFG_W-1:0]           cfg_data
);

  localparam int SW    = wsc_pkg::SAMPLE_W;
  localparam int LOG_D = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = SW + LOG_D;
  localparam logic [LOG_D-1:0] LAST_CELL = LOG_D'(WINDOW_DEPTH - 1);

  wsc_pkg::state_t     state, state_next;
  wsc_pkg::cell_ctrl_t cell_ctrl;

  logic [SW-1:0]    cell_q [WINDOW_DEPTH];
  logic [SW-1:0]    head_din;
  logic [SW-1:0]    tail;
  logic [LOG_D-1:0] walk_cnt;
  logic             walk_last;
  logic             first;
  logic [SW-1:0]    hi, hi_next;
  logic [SW-1:0]    lo, lo_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic             clear_pend;
  logic             accept;
  logic             load_out;
  logic             div_start;
  logic             div_done;
  logic [SW-1:0]    div_q;
  logic [SW-1:0]    stable_spread, low_threshold, high_threshold;
  logic [SW-1:0]    spread_w;
  wsc_pkg::result_t res_w;

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == wsc_pkg::ST_IDLE);
  assign tail       = cell_q[WINDOW_DEPTH-1];
  assign walk_last  = (walk_cnt == LAST_CELL);
  assign first      = (walk_cnt == '0);

  // Rotate the ring during the walk, take the new sample at the head otherwise.
  assign head_din        = (state == wsc_pkg::ST_WALK) ? tail : item.sample;
  assign cell_ctrl.shift = (accept && item.cmd == wsc_pkg::CMD_SAMPLE)
                           || (state == wsc_pkg::ST_WALK);
  assign cell_ctrl.clear = accept && item.cmd == wsc_pkg::CMD_CLEAR;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      wsc_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (cell_ctrl),
        .din  (head_din),
        .dout (cell_q[i])
      );
    end else begin : g_body
      wsc_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (cell_ctrl),
        .din  (cell_q[i-1]),
        .dout (cell_q[i])
      );
    end
  end

  always_comb begin
    hi_next  = (first || tail > hi) ? tail : hi;
    lo_next  = (first || tail < lo) ? tail : lo;
    sum_next = (first ? '0 : sum) + SUM_W'(tail);
  end

  assign div_start = (state == wsc_pkg::ST_WALK) && walk_last;

  wsc_divider #(
    .DIVISOR (WINDOW_DEPTH),
    .HI_W    (LOG_D)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_hi (sum_next[SUM_W-1:SW]),
    .dividend_lo (sum_next[SW-1:0]),
    .done        (div_done),
    .quotient    (div_q)
  );

  always_comb begin
    spread_w = hi - lo;
    res_w    = '0;
    if (!clear_pend && spread_w < stable_spread) begin
      res_w.stable     = 1'b1;
      res_w.mean_value = div_q;
      priority if (div_q < low_threshold) begin
        res_w.level = wsc_pkg::LEVEL_LOW;
      end else if (div_q > high_threshold) begin
        res_w.level = wsc_pkg::LEVEL_HIGH;
      end else begin
        res_w.level = wsc_pkg::LEVEL_BAND;
      end
    end
    if (!clear_pend) begin
      res_w.spread = spread_w;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      wsc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (item.cmd == wsc_pkg::CMD_CLEAR) ? wsc_pkg::ST_FINISH
                                                        : wsc_pkg::ST_WALK;
        end
      end
      wsc_pkg::ST_WALK: begin
        if (walk_last) begin
          state_next = wsc_pkg::ST_DIVIDE;
        end
      end
      wsc_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = wsc_pkg::ST_FINISH;
        end
      end
      wsc_pkg::ST_FINISH: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = wsc_pkg::ST_IDLE;
        end
      end
      default: state_next = wsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_cnt   <= '0;
      clear_pend <= 1'b0;
    end else begin
      if (accept) begin
        walk_cnt   <= '0;
        clear_pend <= (item.cmd == wsc_pkg::CMD_CLEAR);
      end else if (state == wsc_pkg::ST_WALK) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == wsc_pkg::ST_WALK) begin
      hi  <= hi_next;
      lo  <= lo_next;
      sum <= sum_next;
    end
  end

  // Hold the result until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= res_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_spread  <= wsc_pkg::STABLE_SPREAD_RST;
      low_threshold  <= wsc_pkg::LOW_THRESHOLD_RST;
      high_threshold <= wsc_pkg::HIGH_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsc_pkg::CFG_STABLE_SPREAD:  stable_spread  <= cfg_data;
        wsc_pkg::CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        wsc_pkg::CFG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/wsc_checker.sv */
// Port-level checks for the window stability classifier, bound to the top level.
// Depends on wsc_pkg and window_stability_classifier_core_defines.svh.
`include "window_stability_classifier_core_defines.svh"

module wsc_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input wsc_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input wsc_pkg::result_t result
);

  // A stalled result beat holds its payload.
  `WSC_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

  // One item in work at a time: busy right after an accepted beat.
  `WSC_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && item_ready, !item_ready, "item taken while another is in work")

  // An unstable window reports no mean and the low level.
  `WSC_ASSERT_NOW(a_unstable_zero, clk, rst, result_valid && !result.stable, result.mean_value == '0 && result.level == wsc_pkg::LEVEL_LOW, "unstable result carries a mean or level")

  // Reset leaves the block empty and ready.
  `WSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !result_valid && item_ready, "block not empty after reset")

endmodule

bind window_stability_classifier_core wsc_checker u_wsc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* test/wsc_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for window_stability_classifier_core: follows register writes and item
// beats, predicts every result beat and compares it field by field. Depends on wsc_pkg.
module wsc_scoreboard #(
  parameter int DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  wsc_pkg::item_t                item,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  wsc_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [wsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsc_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending
);
  import wsc_pkg::*;

  logic [SAMPLE_W-1:0] temps [DEPTH];
  int unsigned         wr_ptr;
  logic [CFG_W-1:0]    spread_lim;
  logic [CFG_W-1:0]    low_lim;
  logic [CFG_W-1:0]    high_lim;
  result_t             expected_results [$];
  int unsigned         results_seen;

  // Clear, or store and rescan the whole window; order of entries is irrelevant.
  function automatic result_t classify_beat(input item_t beat);
    result_t             r;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    logic [31:0]         sum;
    logic [31:0]         avg;
    r = '0;
    if (beat.cmd == CMD_CLEAR) begin
      foreach (temps[i]) temps[i] = '0;
      return r;
    end
    temps[wr_ptr] = beat.sample;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    hi = temps[0];
    lo = temps[0];
    sum = '0;
    foreach (temps[i]) begin
      if (temps[i] > hi) hi = temps[i];
      if (temps[i] < lo) lo = temps[i];
      sum = sum + temps[i];
    end
    r.spread = hi - lo;
    if (r.spread < spread_lim) begin
      r.stable = 1'b1;
      avg = sum / DEPTH;
      r.mean_value = avg[SAMPLE_W-1:0];
      // low test first, so with crossed thresholds a mean between them gives a low level
      if (r.mean_value < low_lim) r.level = LEVEL_LOW;
      else if (r.mean_value > high_lim) r.level = LEVEL_HIGH;
      else r.level = LEVEL_BAND;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("%0t wsc_scoreboard: result beat %0d %s got %0d expected %0d",
             $time, results_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    result_t want;
    if (rst) begin
      foreach (temps[i]) temps[i] = '0;
      wr_ptr = 0;
      spread_lim = STABLE_SPREAD_RST;
      low_lim = LOW_THRESHOLD_RST;
      high_lim = HIGH_THRESHOLD_RST;
      expected_results.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STABLE_SPREAD: spread_lim = cfg_data;
          CFG_LOW_THRESHOLD: low_lim = cfg_data;
          CFG_HIGH_THRESHOLD: high_lim = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) expected_results.push_back(classify_beat(item));
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("with nothing expected, spread", 32'(result.spread), 0);
        end else begin
          want = expected_results.pop_front();
          if (result.stable !== want.stable)
            report_mismatch("stable", 32'(result.stable), 32'(want.stable));
          if (result.spread !== want.spread)
            report_mismatch("spread", 32'(result.spread), 32'(want.spread));
          if (result.mean_value !== want.mean_value)
            report_mismatch("mean_value", 32'(result.mean_value), 32'(want.mean_value));
          if (result.level !== want.level)
            report_mismatch("level", 32'(result.level), 32'(want.level));
        end
        results_seen++;
      end
    end
    pending = expected_results.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for window_stability_classifier_core: makes sample and clear beats,
// register writes and result back-pressure, and gives the verdict. Needs wsc_pkg, wsc_scoreboard.
module tb_top;
  import wsc_pkg::*;

  localparam int DEPTH         = 8;
  localparam int PHASES        = 14;
  localparam int PHASE_BEATS   = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   mismatches;
  int                   pending;
  bit                   no_gaps = 1'b0;
  int                   hold_reqs = 0;
  int                   holds_served = 0;
  int                   idle_cycles = 0;

  always #10 clk = ~clk;

  window_stability_classifier_core #(.WINDOW_DEPTH(DEPTH)) u_dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result,
    .cfg_we, .cfg_index, .cfg_data
  );

  wsc_scoreboard #(.DEPTH(DEPTH)) u_check (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .pending
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
    return v[SAMPLE_W-1:0];
  endfunction

  // Offer one beat; valid stays high after acceptance unless a gap follows.
  task automatic send_beat(input logic cmd, input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.cmd = cmd;
    item.sample = sample;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drain the block before touching its registers.
  task automatic set_limits(input logic [CFG_W-1:0] spread_lim, input logic [CFG_W-1:0] low_lim,
                            input logic [CFG_W-1:0] high_lim);
    @(negedge clk);
    item_valid = 1'b0;
    wait (pending == 0);
    write_reg(CFG_STABLE_SPREAD, spread_lim);
    write_reg(CFG_LOW_THRESHOLD, low_lim);
    write_reg(CFG_HIGH_THRESHOLD, high_lim);
  endtask

  initial begin : result_side
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_served) begin
        holds_served++;
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (no_gaps) begin
        result_ready = 1'b1;
      end else if (stall > 0) begin
        result_ready = 1'b0;
        stall--;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        result_ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int base;
    int jitter;
    int k;
    int r;
    logic [CFG_W-1:0] spread_lim;
    logic [CFG_W-1:0] low_lim;
    logic [CFG_W-1:0] high_lim;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset limits; the first sample sees a zero-filled window.
    send_beat(CMD_SAMPLE, 16'd375);
    send_beat(CMD_CLEAR, SAMPLE_MAX);
    send_beat(CMD_SAMPLE, '0);
    repeat (7) send_beat(CMD_SAMPLE, SAMPLE_MAX);
    // full window near the top: the sum needs more than 16 bits
    send_beat(CMD_SAMPLE, SAMPLE_MAX - 1'b1);
    send_beat(CMD_CLEAR, '0);

    // Crossed thresholds with the widest spread limit.
    set_limits(SAMPLE_MAX, 16'd400, 16'd300);
    send_beat(CMD_SAMPLE, SAMPLE_MAX);
    send_beat(CMD_CLEAR, '0);
    send_beat(CMD_SAMPLE, 16'd2800);
    send_beat(CMD_SAMPLE, 16'd5000);

    // Spread limit of zero: never stable. The spare index must be ignored.
    set_limits('0, '0, SAMPLE_MAX);
    write_reg(CFG_SPARE, SAMPLE_MAX);
    send_beat(CMD_CLEAR, '0);
    send_beat(CMD_SAMPLE, '0);

    // Both thresholds at zero: an all-zero window sits in the band.
    set_limits(16'd1, '0, '0);
    write_reg(CFG_SPARE, '0);
    send_beat(CMD_SAMPLE, '0);
    send_beat(CMD_CLEAR, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      r = $urandom_range(0, 9);
      if (r == 0) base = $urandom_range(0, 4);
      else if (r == 1) base = int'(SAMPLE_MAX) - int'($urandom_range(0, 4));
      else if (r < 5) base = $urandom_range(0, int'(SAMPLE_MAX));
      else base = $urandom_range(300, 450);
      jitter = $urandom_range(0, 4);
      k = $urandom_range(0, 3);

      r = $urandom_range(0, 9);
      if (r == 0) spread_lim = '0;
      else if (r == 1) spread_lim = SAMPLE_MAX;
      else if (r == 2) spread_lim = CFG_W'($urandom_range(0, int'(SAMPLE_MAX)));
      else spread_lim = CFG_W'($urandom_range(1, 2 * jitter + 3));

      r = $urandom_range(0, 9);
      if (r == 0) begin
        low_lim = '0;
        high_lim = SAMPLE_MAX;
      end else if (r == 1) begin
        low_lim = SAMPLE_MAX;
        high_lim = '0;
      end else if (r == 2) begin
        low_lim = clamp_sample(base + k);
        high_lim = clamp_sample(base - k);
      end else begin
        low_lim = clamp_sample(base - k);
        high_lim = clamp_sample(base + k);
      end

      if (ph == 0) begin
        spread_lim = STABLE_SPREAD_RST;
        low_lim = LOW_THRESHOLD_RST;
        high_lim = HIGH_THRESHOLD_RST;
        base = 375;
      end
      set_limits(spread_lim, low_lim, high_lim);
      write_reg(CFG_SPARE, CFG_W'($urandom_range(0, int'(SAMPLE_MAX))));

      no_gaps = (ph % 4 == 3);
      // hold the result side off so the block backs up into its input
      if (ph == 2) hold_reqs++;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_beat(CMD_CLEAR, SAMPLE_W'($urandom_range(0, int'(SAMPLE_MAX))));
        end else if (r < 12) begin
          send_beat(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, int'(SAMPLE_MAX))));
        end else begin
          if ($urandom_range(0, 19) == 0) base = base + int'($urandom_range(0, 20)) - 10;
          send_beat(CMD_SAMPLE,
                    clamp_sample(base + int'($urandom_range(0, 2 * jitter)) - jitter));
        end
      end
    end

    @(negedge clk);
    item_valid = 1'b0;
    no_gaps = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
